FILE: sv/ewafbc_pkg.sv
`timescale 1ns / 1ps

package ewafbc_pkg;

    localparam int BETA_BITS       = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTHING = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIAS_EN   = 1'd1;

    localparam logic [BETA_BITS-1:0] SMOOTHING_RESET = 16'd58982;
    localparam logic                 BIAS_EN_RESET   = 1'b1;

    localparam logic [BETA_BITS:0] BETA_ONE  = 17'd65536;
    localparam logic [BETA_BITS:0] BETA_HALF = 17'd32768;

    typedef struct packed {
        logic clear;
        logic load;
        logic mul;
        logic acc;
        logic setup;
        logic div;
        logic fin;
    } t_dp_cmd;

endpackage

FILE: sv/ewafbc_ctrl.sv
`timescale 1ns / 1ps

module ewafbc_ctrl #(
    parameter int SAMPLE_BITS = ewafbc_pkg::SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    output ewafbc_pkg::t_dp_cmd o_cmd
);
    import ewafbc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLE_BITS - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_ACC   = 6'b000100,
        S_SETUP = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.clear = i_cfg_we;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_cnt       = CNT_W'(SAMPLE_BITS - 2);
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.fin | (r_out_valid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/ewafbc_dp.sv
`timescale 1ns / 1ps

module ewafbc_dp #(
    parameter int FRAC_BITS   = ewafbc_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = ewafbc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ewafbc_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic [ewafbc_pkg::BETA_BITS-1:0]     i_beta,
    input  logic                                 i_bias_en,
    output logic signed [SAMPLE_BITS-1:0]        o_filtered
);
    import ewafbc_pkg::*;

    localparam int VW  = SAMPLE_BITS + FRAC_BITS;
    localparam int PVW = VW + BETA_BITS + 1;
    localparam int PXW = SAMPLE_BITS + BETA_BITS + 2;
    localparam int AW  = VW + BETA_BITS + 2;
    localparam int BPW = 2 * BETA_BITS + 1;
    localparam int NW  = VW + BETA_BITS + 1;
    localparam int QW  = SAMPLE_BITS - 1;

    logic signed [VW-1:0]      r_v;
    logic [BETA_BITS:0]        r_bp;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [PVW-1:0]     r_p_v;
    logic signed [PXW-1:0]     r_p_x;
    logic [BPW-1:0]            r_bp_prod;
    logic [NW-1:0]             r_rem;
    logic [NW-1:0]             r_dsh;
    logic [QW-1:0]             r_q;
    logic                      r_neg;
    logic                      r_sat;

    logic signed [BETA_BITS:0]   w_beta_s;
    logic [BETA_BITS:0]          w_omb;
    logic signed [BETA_BITS+1:0] w_omb_s;
    logic signed [PVW-1:0]       w_p_v;
    logic signed [PXW-1:0]       w_p_x;
    logic signed [AW-1:0]        w_acc;
    logic [BPW:0]                w_bp_sum;
    logic [BETA_BITS:0]          w_div;
    logic                        w_neg;
    logic [VW-1:0]               w_mag;
    logic [NW-1:0]               w_num;
    logic [NW-1:0]               w_lim;
    logic                        w_ge;
    logic [SAMPLE_BITS-1:0]      w_qe;
    logic signed [SAMPLE_BITS-1:0] w_out;

    always_comb begin
        w_beta_s = $signed({1'b0, i_beta});
        w_omb    = BETA_ONE - {1'b0, i_beta};
        w_omb_s  = $signed({1'b0, w_omb});
        w_p_v    = PVW'(w_beta_s) * PVW'(r_v);
        w_p_x    = PXW'(w_omb_s) * PXW'(r_x);

        w_acc    = AW'(r_p_v) + (AW'(r_p_x) <<< FRAC_BITS) + $signed(AW'(BETA_HALF));
        w_bp_sum = {1'b0, r_bp_prod} + (BPW + 1)'(BETA_HALF);

        w_div = (i_bias_en && !r_bp[BETA_BITS]) ? (BETA_ONE - r_bp) : BETA_ONE;
        w_neg = r_v[VW-1];
        w_mag = w_neg ? (~unsigned'(r_v) + 1'b1) : unsigned'(r_v);
        w_num = (NW'(w_mag) << BETA_BITS) + (NW'(w_div) << (FRAC_BITS - 1));
        w_lim = NW'(w_div) << (FRAC_BITS + SAMPLE_BITS - 1);

        w_ge  = (r_rem >= r_dsh);

        w_qe  = {1'b0, r_q};
        if (r_sat) begin
            w_out = r_neg ? $signed({1'b1, {QW{1'b0}}}) : $signed({1'b0, {QW{1'b1}}});
        end else begin
            w_out = r_neg ? $signed(~w_qe + 1'b1) : $signed(w_qe);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_bp <= BETA_ONE;
        end else if (i_cmd.clear) begin
            r_v  <= '0;
            r_bp <= BETA_ONE;
        end else if (i_cmd.acc) begin
            r_v  <= w_acc[BETA_BITS +: VW];
            r_bp <= w_bp_sum[BETA_BITS +: BETA_BITS + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample;
        end
        if (i_cmd.mul) begin
            r_p_v     <= w_p_v;
            r_p_x     <= w_p_x;
            r_bp_prod <= BPW'(r_bp) * BPW'(i_beta);
        end
        if (i_cmd.setup) begin
            r_rem <= w_num;
            r_dsh <= NW'(w_div) << (FRAC_BITS + SAMPLE_BITS - 2);
            r_q   <= '0;
            r_neg <= w_neg;
            r_sat <= (w_num >= w_lim);
        end
        if (i_cmd.div) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[QW-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.fin) begin
            o_filtered <= w_out;
        end
    end

endmodule

FILE: sv/ewa_filter_bias_corrected_unit.sv
`timescale 1ns / 1ps
// Bias-corrected exponential moving average.
// Input channel: i_in_valid / o_in_stall carry one signed sample per beat.
// Output channel: o_out_valid / i_out_stall carry one filtered value per beat,
// exactly one result for every input beat, in order.
// Config port: i_cfg_we with i_cfg_idx selects smoothing factor (0) or bias
// correction enable (1); any write also clears the average and beta power.
// Write config only while no sample is in flight.
// Each sample is loaded, then passes through a multiply, an accumulate and a
// setup step and the restoring divider, which retires one quotient bit per
// cycle over SAMPLE_BITS - 1 steps, before the result is loaded into the
// output register. A new sample is taken only after that load.
// A finished result sits in the output register; the next sample is taken
// while it waits. If the receiver stalls past the next result, the block
// holds that result internally and stalls its input.
// Reset: synchronous, active low; restores register defaults, clears the
// average to zero and beta power to one, and drops any pending beat.
module ewa_filter_bias_corrected_unit #(
    parameter int FRAC_BITS   = ewafbc_pkg::FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = ewafbc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_filtered,
    input  logic                                  i_cfg_we,
    input  logic [ewafbc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ewafbc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ewafbc_pkg::*;

    logic [BETA_BITS-1:0] r_smoothing;
    logic                 r_bias_en;
    t_dp_cmd              w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing <= SMOOTHING_RESET;
            r_bias_en   <= BIAS_EN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SMOOTHING: r_smoothing <= i_cfg_data[BETA_BITS-1:0];
                CFG_BIAS_EN:   r_bias_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ewafbc_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .o_cmd       (w_cmd)
    );

    ewafbc_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_sample   (i_sample),
        .i_beta     (r_smoothing),
        .i_bias_en  (r_bias_en),
        .o_filtered (o_filtered)
    );

endmodule
